>>> rtl/core/dakf_pkg.sv
// ----------------------------------------------------------------------------
// dakf_pkg: shared definitions for the dual angle Kalman filter
// Types, constants and helpers used by the filter channels and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dakf_pkg;

  // Fraction bits of the sample interval; fixed whatever FRAC_BITS is.
  localparam int DT_BITS       = 16;
  localparam int FRAC_BITS_DEF = 16;
  // Width in which the angle sums are formed before saturation.
  localparam int SAT_W         = 48;
  // Multiplicand width of the shared multiplier in the top level.
  localparam int TOP_MW        = 32;
  // Multiplicand width inside a channel (error term of 33 bits).
  localparam int CH_MW         = 33;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_VARIANCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_VARIANCE = 2'd2;

  localparam logic [DT_BITS-1:0] TIME_STEP_RESET = 16'd6554;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_DT2,
    TS_Q,
    TS_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PRED,
    CS_WAITQ,
    CS_PREP,
    CS_DIV,
    CS_MGAIN,
    CS_MVAR
  } chan_state_t;

  typedef struct packed {
    logic start;
    logic q_valid;
  } chan_ctl_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat_s32(input logic signed [SAT_W-1:0] x);
    logic fits;
    fits = (&x[SAT_W-1:31]) || !(|x[SAT_W-1:31]);
    if (fits) begin
      return x[31:0];
    end else if (x[SAT_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dakf_mul.sv
// ----------------------------------------------------------------------------
// dakf_mul: bit-serial signed by unsigned multiplier
// Consumes one multiplier bit per cycle, LSB first, with a shift-right
// accumulator; the adder is only as wide as the multiplicand plus one.
// ----------------------------------------------------------------------------
`default_nettype none

module dakf_mul
  import dakf_pkg::*;
#(
  parameter int MW = TOP_MW,
  parameter int NW = DT_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] mcand,
  input  wire logic [NW-1:0]        mplr,
  output logic                      done,
  output logic signed [MW+NW:0]     prod
);

  localparam int PW = MW + NW + 1;
  localparam int CW = $clog2(NW + 1);

  logic [PW-1:0]        acc_r, acc_nxt;
  logic signed [MW-1:0] mcand_r, mcand_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [MW:0]   hi;
  logic signed [MW:0]   addend;
  logic signed [MW:0]   sum;

  always_comb begin
    hi        = signed'(acc_r[PW-1:NW]);
    addend    = acc_r[0] ? (MW+1)'(mcand_r) : '0;
    sum       = hi + addend;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      acc_nxt   = {{(MW+1){1'b0}}, mplr};
      mcand_nxt = mcand;
      cnt_nxt   = CW'(NW);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      // Add the partial product, then shift one bit towards the low end.
      acc_nxt = {sum[MW], sum, acc_r[NW-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
  end

  assign done = done_r;
  assign prod = signed'(acc_r);

endmodule

`default_nettype wire

>>> rtl/core/dakf_chan.sv
// ----------------------------------------------------------------------------
// dakf_chan: one scalar Kalman channel
// Holds the angle and variance of one axis. Predicts, divides for the gain
// with a restoring divider one quotient bit per cycle, and updates both
// values through a bit-serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dakf_chan
  import dakf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire chan_ctl_t           ctl,
  input  wire logic [DT_BITS-1:0]  time_step,
  input  wire logic [30:0]         q,
  input  wire logic [30:0]         measure_variance,
  input  wire logic signed [31:0]  rate,
  input  wire logic signed [31:0]  measured,
  output logic                     done,
  output logic signed [31:0]       angle,
  output logic [30:0]              variance
);

  localparam int MB  = (FRAC_BITS + 1 > DT_BITS) ? FRAC_BITS + 1 : DT_BITS;
  localparam int PW  = CH_MW + MB + 1;
  localparam int DCW = $clog2(FRAC_BITS + 2);
  localparam logic [FRAC_BITS:0] GainOne  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [30:0]        VarReset = 31'(64'd4 << FRAC_BITS);

  chan_state_t state_r, state_nxt;

  logic                    mul_start;
  logic signed [CH_MW-1:0] mul_mcand;
  logic [MB-1:0]           mul_mplr;
  logic                    mul_done;
  logic signed [PW-1:0]    mul_prod;

  logic signed [31:0]      meas_r, meas_nxt;
  logic signed [31:0]      a1_r, a1_nxt;
  logic [30:0]             p1_r, p1_nxt;
  logic [31:0]             den_r, den_nxt;
  logic                    den_nz_r, den_nz_nxt;
  logic [32:0]             rem_r, rem_nxt;
  logic signed [32:0]      e_r, e_nxt;
  logic [FRAC_BITS:0]      gain_r, gain_nxt;
  logic [DCW-1:0]          div_cnt_r, div_cnt_nxt;
  logic signed [31:0]      angle_r, angle_nxt;
  logic [30:0]             var_r, var_nxt;

  logic signed [SAT_W-1:0] pred_sum;
  logic signed [SAT_W-1:0] upd_sum;
  logic [31:0]             p1_sum;
  logic [31:0]             den_sum;
  logic [32:0]             div_trial;
  logic                    div_bit;
  logic                    div_last;
  logic [FRAC_BITS:0]      gain_shift;
  logic [30:0]             var_upd;

  dakf_mul #(
    .MW (CH_MW),
    .NW (MB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mplr  (mul_mplr),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Arithmetic around the multiplier and divider.
  always_comb begin
    pred_sum   = SAT_W'(angle_r) + SAT_W'(signed'(mul_prod[PW-1:DT_BITS]))
               + SAT_W'(mul_prod[DT_BITS-1]);
    upd_sum    = SAT_W'(a1_r) + SAT_W'(signed'(mul_prod[PW-1:FRAC_BITS]))
               + SAT_W'(mul_prod[FRAC_BITS-1]);
    p1_sum     = {1'b0, var_r} + {1'b0, q};
    den_sum    = {1'b0, p1_r} + {1'b0, measure_variance};
    div_trial  = rem_r - {1'b0, den_r};
    div_bit    = den_nz_r && (rem_r >= {1'b0, den_r});
    div_last   = (div_cnt_r == DCW'(1));
    gain_shift = {gain_r[FRAC_BITS-1:0], div_bit};
    // The rounded product never exceeds the predicted variance.
    var_upd    = mul_prod[FRAC_BITS+30:FRAC_BITS] + 31'(mul_prod[FRAC_BITS-1]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE:  if (ctl.start) state_nxt = CS_PRED;
      CS_PRED:  if (mul_done) state_nxt = CS_WAITQ;
      CS_WAITQ: if (ctl.q_valid) state_nxt = CS_PREP;
      CS_PREP:  state_nxt = CS_DIV;
      CS_DIV:   if (div_last) state_nxt = CS_MGAIN;
      CS_MGAIN: if (mul_done) state_nxt = CS_MVAR;
      CS_MVAR:  if (mul_done) state_nxt = CS_IDLE;
      default:  state_nxt = CS_IDLE;
    endcase
  end

  // Multiplier control and status.
  always_comb begin
    mul_start = 1'b0;
    mul_mcand = CH_MW'(rate);
    mul_mplr  = MB'(time_step);
    done      = 1'b0;
    case (state_r)
      CS_IDLE: begin
        mul_start = ctl.start;
      end
      CS_DIV: begin
        mul_start = div_last;
        mul_mcand = e_r;
        mul_mplr  = MB'(gain_shift);
      end
      CS_MGAIN: begin
        mul_start = mul_done;
        mul_mcand = signed'({2'b00, p1_r});
        mul_mplr  = MB'(GainOne - gain_r);
      end
      CS_MVAR: begin
        done = mul_done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    meas_nxt    = meas_r;
    a1_nxt      = a1_r;
    p1_nxt      = p1_r;
    den_nxt     = den_r;
    den_nz_nxt  = den_nz_r;
    rem_nxt     = rem_r;
    e_nxt       = e_r;
    gain_nxt    = gain_r;
    div_cnt_nxt = div_cnt_r;
    angle_nxt   = angle_r;
    var_nxt     = var_r;
    case (state_r)
      CS_IDLE: begin
        if (ctl.start) meas_nxt = measured;
      end
      CS_PRED: begin
        if (mul_done) a1_nxt = sat_s32(pred_sum);
      end
      CS_WAITQ: begin
        if (ctl.q_valid) p1_nxt = p1_sum[31] ? '1 : p1_sum[30:0];
      end
      CS_PREP: begin
        den_nxt     = den_sum;
        den_nz_nxt  = |den_sum;
        rem_nxt     = {2'b00, p1_r};
        e_nxt       = 33'(meas_r) - 33'(a1_r);
        div_cnt_nxt = DCW'(FRAC_BITS + 1);
      end
      CS_DIV: begin
        // The first step yields the integer bit, set only when R is zero.
        gain_nxt    = gain_shift;
        rem_nxt     = div_bit ? {div_trial[31:0], 1'b0} : {rem_r[31:0], 1'b0};
        div_cnt_nxt = div_cnt_r - DCW'(1);
      end
      CS_MGAIN: begin
        if (mul_done) angle_nxt = sat_s32(upd_sum);
      end
      CS_MVAR: begin
        if (mul_done) var_nxt = var_upd;
      end
      default: begin
        meas_nxt = meas_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      angle_r <= '0;
      var_r   <= VarReset;
    end else begin
      state_r <= state_nxt;
      angle_r <= angle_nxt;
      var_r   <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r    <= meas_nxt;
    a1_r      <= a1_nxt;
    p1_r      <= p1_nxt;
    den_r     <= den_nxt;
    den_nz_r  <= den_nz_nxt;
    rem_r     <= rem_nxt;
    e_r       <= e_nxt;
    gain_r    <= gain_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  assign angle    = angle_r;
  assign variance = var_r;

endmodule

`default_nettype wire

>>> rtl/core/dual_angle_kalman_1d.sv
// ----------------------------------------------------------------------------
// dual_angle_kalman_1d: roll and pitch scalar Kalman filter
// Two independent channels fuse gyro rates with accelerometer angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries both gyro rates and both
//   measured angles; a transaction takes place when in_valid is high and
//   in_stall is low. Output channel (out_valid / out_stall) carries both
//   filtered angles and both variances, one transaction per input.
//   The configuration port writes time_step, rate_variance and
//   measure_variance by index; the user must write them only while the
//   filter is idle, as the block itself has no check for it.
//   The result is formed by the bit-serial multipliers, one multiplier bit
//   per cycle, and the restoring divider, one gain bit per cycle. The shared
//   term dt*dt*rate_variance is formed first on one multiplier while both
//   channels run their angle prediction on their own multipliers.
//   One item is processed at a time; in_stall stays high until its result
//   is in the output register. If the receiver stalls, the result is held
//   and the next transaction may already be taken and computed; it then
//   waits for the register. Reset restores the default registers, zero
//   angles and variances of 4.0.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_angle_kalman_1d
  import dakf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [31:0]    in_roll_rate,
  input  wire logic signed [31:0]    in_pitch_rate,
  input  wire logic signed [31:0]    in_roll_measured,
  input  wire logic signed [31:0]    in_pitch_measured,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [31:0]         out_roll_estimate,
  output logic [30:0]                out_roll_uncertainty,
  output logic signed [31:0]         out_pitch_estimate,
  output logic [30:0]                out_pitch_uncertainty
);

  localparam int PW = TOP_MW + DT_BITS + 1;
  localparam logic [30:0] RvReset = 31'(64'd100 << FRAC_BITS);
  localparam logic [30:0] MvReset = 31'(64'd9 << FRAC_BITS);

  top_state_t state_r, state_nxt;

  logic [DT_BITS-1:0] ts_r, ts_nxt;
  logic [30:0]        rv_r, rv_nxt;
  logic [30:0]        mv_r, mv_nxt;
  logic [30:0]        q_r, q_nxt;
  logic               q_valid_r, q_valid_nxt;
  logic               roll_done_r, roll_done_nxt;
  logic               pitch_done_r, pitch_done_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] roll_est_r, roll_est_nxt;
  logic [30:0]        roll_unc_r, roll_unc_nxt;
  logic signed [31:0] pitch_est_r, pitch_est_nxt;
  logic [30:0]        pitch_unc_r, pitch_unc_nxt;

  logic                     accept;
  logic                     load_out;
  logic                     mul_start;
  logic signed [TOP_MW-1:0] mul_mcand;
  logic [DT_BITS-1:0]       mul_mplr;
  logic                     mul_done;
  logic signed [PW-1:0]     mul_prod;
  logic [DT_BITS-1:0]       dt2;
  logic [30:0]              q_calc;

  chan_ctl_t          chan_ctl;
  logic               roll_done, pitch_done;
  logic signed [31:0] roll_angle, pitch_angle;
  logic [30:0]        roll_var, pitch_var;

  assign accept   = in_valid && !in_stall;
  assign chan_ctl = '{start: accept, q_valid: q_valid_r};

  // Rounded dt squared, then the shared variance growth per sample.
  assign dt2    = mul_prod[2*DT_BITS-1:DT_BITS] + DT_BITS'(mul_prod[DT_BITS-1]);
  assign q_calc = mul_prod[DT_BITS+30:DT_BITS] + 31'(mul_prod[DT_BITS-1]);

  dakf_mul #(
    .MW (TOP_MW),
    .NW (DT_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mplr  (mul_mplr),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dakf_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_roll (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (chan_ctl),
    .time_step        (ts_r),
    .q                (q_r),
    .measure_variance (mv_r),
    .rate             (in_roll_rate),
    .measured         (in_roll_measured),
    .done             (roll_done),
    .angle            (roll_angle),
    .variance         (roll_var)
  );

  dakf_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pitch (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (chan_ctl),
    .time_step        (ts_r),
    .q                (q_r),
    .measure_variance (mv_r),
    .rate             (in_pitch_rate),
    .measured         (in_pitch_measured),
    .done             (pitch_done),
    .angle            (pitch_angle),
    .variance         (pitch_var)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_IDLE: if (accept) state_nxt = TS_DT2;
      TS_DT2:  if (mul_done) state_nxt = TS_Q;
      TS_Q:    if (mul_done) state_nxt = TS_WAIT;
      TS_WAIT: if (load_out) state_nxt = TS_IDLE;
      default: state_nxt = TS_IDLE;
    endcase
  end

  // Handshake and multiplier control.
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    mul_mcand = signed'(TOP_MW'(ts_r));
    mul_mplr  = ts_r;
    load_out  = 1'b0;
    case (state_r)
      TS_IDLE: begin
        in_stall  = 1'b0;
        mul_start = accept;
      end
      TS_DT2: begin
        mul_start = mul_done;
        mul_mcand = signed'({1'b0, rv_r});
        mul_mplr  = dt2;
      end
      TS_WAIT: begin
        load_out = roll_done_r && pitch_done_r && (!out_valid_r || !out_stall);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Registers, transaction bookkeeping and the output register.
  always_comb begin
    ts_nxt         = ts_r;
    rv_nxt         = rv_r;
    mv_nxt         = mv_r;
    q_nxt          = q_r;
    q_valid_nxt    = q_valid_r;
    roll_done_nxt  = roll_done_r || roll_done;
    pitch_done_nxt = pitch_done_r || pitch_done;
    out_valid_nxt  = out_valid_r && out_stall;
    roll_est_nxt   = roll_est_r;
    roll_unc_nxt   = roll_unc_r;
    pitch_est_nxt  = pitch_est_r;
    pitch_unc_nxt  = pitch_unc_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIME_STEP:        ts_nxt = cfg_wr_data[DT_BITS-1:0];
        CFG_RATE_VARIANCE:    rv_nxt = cfg_wr_data[30:0];
        CFG_MEASURE_VARIANCE: mv_nxt = cfg_wr_data[30:0];
        default:              ts_nxt = ts_r;
      endcase
    end
    if (accept) begin
      q_valid_nxt    = 1'b0;
      roll_done_nxt  = 1'b0;
      pitch_done_nxt = 1'b0;
    end
    if ((state_r == TS_Q) && mul_done) begin
      q_nxt       = q_calc;
      q_valid_nxt = 1'b1;
    end
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      roll_done_nxt  = 1'b0;
      pitch_done_nxt = 1'b0;
      roll_est_nxt   = roll_angle;
      roll_unc_nxt   = roll_var;
      pitch_est_nxt  = pitch_angle;
      pitch_unc_nxt  = pitch_var;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= TS_IDLE;
      ts_r         <= TIME_STEP_RESET;
      rv_r         <= RvReset;
      mv_r         <= MvReset;
      q_valid_r    <= 1'b0;
      roll_done_r  <= 1'b0;
      pitch_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ts_r         <= ts_nxt;
      rv_r         <= rv_nxt;
      mv_r         <= mv_nxt;
      q_valid_r    <= q_valid_nxt;
      roll_done_r  <= roll_done_nxt;
      pitch_done_r <= pitch_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    roll_est_r  <= roll_est_nxt;
    roll_unc_r  <= roll_unc_nxt;
    pitch_est_r <= pitch_est_nxt;
    pitch_unc_r <= pitch_unc_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_roll_estimate     = roll_est_r;
  assign out_roll_uncertainty  = roll_unc_r;
  assign out_pitch_estimate    = pitch_est_r;
  assign out_pitch_uncertainty = pitch_unc_r;

`ifndef ASSERT_OFF
  // Once a transaction is taken, no further one is taken until it completes.
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken while a transaction was in progress");

  // A new result only appears after both channels have finished.
  a_rose_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r == TS_WAIT) && $past(roll_done_r)
                          && $past(pitch_done_r)))
    else $error("result presented before both channels finished");

  // No stale completion flag survives into the idle state.
  a_idle_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TS_IDLE) |-> (!roll_done_r && !pitch_done_r))
    else $error("channel completion flag set while idle");

  // The shared multiplier only finishes while the variance term is formed.
  a_mul_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> ((state_r == TS_DT2) || (state_r == TS_Q)))
    else $error("shared multiplier finished outside its phases");
`endif

endmodule

`default_nettype wire

>>> verif/dual_angle_kalman_1d_tb.sv
// ----------------------------------------------------------------------------
// dual_angle_kalman_1d_tb: self-checking bench for the roll and pitch filter
// Drives a table of directed transactions, then random sensor samples under
// changing register settings and idling profiles. Each result is checked against
// a bit-exact fixed-point model of both filter channels or, for typed rows, the table entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_angle_kalman_1d_tb;
  import dakf_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int LATENCY      = 3 * FRAC + 42;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 600;
  localparam int SEG_ITEMS    = 150;
  localparam int SEGS_PER_MODE = 3;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic signed [31:0]   S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   S32_MIN = 32'sh8000_0000;
  localparam longint               VAR_MAX = 64'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] roll_measured;
    logic signed [31:0] pitch_measured;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll_estimate;
    logic [30:0]        roll_uncertainty;
    logic signed [31:0] pitch_estimate;
    logic [30:0]        pitch_uncertainty;
  } estimate_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    sample_t                smp;
    logic                   typed;
    estimate_t              est;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [31:0]      in_roll_rate = '0;
  logic signed [31:0]      in_pitch_rate = '0;
  logic signed [31:0]      in_roll_measured = '0;
  logic signed [31:0]      in_pitch_measured = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [31:0]      out_roll_estimate;
  logic [30:0]             out_roll_uncertainty;
  logic signed [31:0]      out_pitch_estimate;
  logic [30:0]             out_pitch_uncertainty;

  // Filter model state and register copies.
  longint pred_angle [2];
  longint pred_variance [2];
  longint dt_reg;
  longint qvar_reg;
  longint rvar_reg;

  estimate_t estimate_q [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  unexpected_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cfg_write_count = 0;

  dual_angle_kalman_1d dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_roll_rate          (in_roll_rate),
    .in_pitch_rate         (in_pitch_rate),
    .in_roll_measured      (in_roll_measured),
    .in_pitch_measured     (in_pitch_measured),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_roll_estimate     (out_roll_estimate),
    .out_roll_uncertainty  (out_roll_uncertainty),
    .out_pitch_estimate    (out_pitch_estimate),
    .out_pitch_uncertainty (out_pitch_uncertainty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, estimate_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic longint round_q(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_s32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic void filter_channel(int ch, longint rate, longint meas);
    longint a1, dt2, p1, den, gain;
    a1  = clamp_s32(pred_angle[ch] + round_q(dt_reg * rate, DT_BITS));
    dt2 = round_q(dt_reg * dt_reg, DT_BITS);
    p1  = pred_variance[ch] + round_q(dt2 * qvar_reg, DT_BITS);
    if (p1 > VAR_MAX) p1 = VAR_MAX;
    den = p1 + rvar_reg;
    // With no uncertainty on either side the measurement is ignored.
    gain = (den != 0) ? (p1 <<< FRAC) / den : 64'sd0;
    pred_angle[ch] = clamp_s32(a1 + round_q(gain * (meas - a1), FRAC));
    p1 = round_q(((64'sd1 <<< FRAC) - gain) * p1, FRAC);
    if (p1 > VAR_MAX) p1 = VAR_MAX;
    pred_variance[ch] = p1;
  endfunction

  function automatic estimate_t filter_step(sample_t s);
    estimate_t e;
    filter_channel(0, longint'($signed(s.roll_rate)), longint'($signed(s.roll_measured)));
    filter_channel(1, longint'($signed(s.pitch_rate)), longint'($signed(s.pitch_measured)));
    e.roll_estimate     = pred_angle[0][31:0];
    e.roll_uncertainty  = pred_variance[0][30:0];
    e.pitch_estimate    = pred_angle[1][31:0];
    e.pitch_uncertainty = pred_variance[1][30:0];
    return e;
  endfunction

  function automatic void filter_reset();
    dt_reg   = longint'(TIME_STEP_RESET);
    qvar_reg = 64'sd100 <<< FRAC;
    rvar_reg = 64'sd9 <<< FRAC;
    for (int ch = 0; ch < 2; ch++) begin
      pred_angle[ch]    = 0;
      pred_variance[ch] = 64'sd4 <<< FRAC;
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic sample_t mk_sample(logic signed [31:0] rr, logic signed [31:0] pr,
                                        logic signed [31:0] rm, logic signed [31:0] pm);
    sample_t s;
    s.roll_rate      = rr;
    s.pitch_rate     = pr;
    s.roll_measured  = rm;
    s.pitch_measured = pm;
    return s;
  endfunction

  function automatic estimate_t mk_est(logic signed [31:0] re, logic [30:0] ru,
                                       logic signed [31:0] pe, logic [30:0] pu);
    estimate_t e;
    e.roll_estimate     = re;
    e.roll_uncertainty  = ru;
    e.pitch_estimate    = pe;
    e.pitch_uncertainty = pu;
    return e;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t item_row(sample_t s, logic typed, estimate_t e);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.smp   = s;
    r.typed = typed;
    r.est   = e;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_field(bit is_rate);
    case ($urandom_range(19))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6, 7, 8: return $urandom;
      default: begin
        // Plausible sensor values: up to 500 deg/s, or up to 180 degrees.
        if (is_rate) return $signed($urandom_range(32'd65536000)) - 32'sd32768000;
        return $signed($urandom_range(32'd23592960)) - 32'sd11796480;
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_TIME_STEP:        dt_reg   = longint'(data[DT_BITS-1:0]);
      CFG_RATE_VARIANCE:    qvar_reg = longint'(data);
      CFG_MEASURE_VARIANCE: rvar_reg = longint'(data);
      default: ;
    endcase
    cfg_write_count++;
    @(posedge clk);
  endtask

  task automatic wait_for_estimates();
    in_valid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input logic typed, input estimate_t typed_est);
    estimate_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_roll_rate      <= s.roll_rate;
    in_pitch_rate     <= s.pitch_rate;
    in_roll_measured  <= s.roll_measured;
    in_pitch_measured <= s.pitch_measured;
    do @(posedge clk); while (in_stall);
    e = filter_step(s);
    estimate_q.push_back(typed ? typed_est : e);
    items_sent++;
  endtask

  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] d;
    case ($urandom_range(7))
      0: d = '0;
      1: d = 31'h0000_FFFF;
      2: d = 31'd1;
      3, 4, 5: d = CFG_DATA_W'($urandom_range(13107, 655));
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(CFG_TIME_STEP, d);
    case ($urandom_range(7))
      0: d = '0;
      1: d = 31'h7FFF_FFFF;
      2, 3, 4, 5: d = CFG_DATA_W'($urandom_range(1000) << FRAC);
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(CFG_RATE_VARIANCE, d);
    case ($urandom_range(15))
      0: d = '0;
      1, 2: d = 31'h7FFF_FFFF;
      3: d = 31'd1;
      4, 5, 6, 7, 8, 9: d = CFG_DATA_W'($urandom_range(100, 1) << FRAC);
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(CFG_MEASURE_VARIANCE, d);
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
  endtask

  // ------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    estimate_t exp_e;
    logic      bad;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (estimate_q.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= MAX_REPORTS)
          $display("[%0d] result transaction with none expected", cycle_count);
      end else begin
        exp_e = estimate_q.pop_front();
        bad = 1'b0;
        if (out_roll_estimate !== exp_e.roll_estimate) bad = 1'b1;
        if (out_roll_uncertainty !== exp_e.roll_uncertainty) bad = 1'b1;
        if (out_pitch_estimate !== exp_e.pitch_estimate) bad = 1'b1;
        if (out_pitch_uncertainty !== exp_e.pitch_uncertainty) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= MAX_REPORTS)
            $display("[%0d] mismatch: exp roll %h/%h pitch %h/%h, got roll %h/%h pitch %h/%h",
                     cycle_count, exp_e.roll_estimate, exp_e.roll_uncertainty,
                     exp_e.pitch_estimate, exp_e.pitch_uncertainty,
                     out_roll_estimate, out_roll_uncertainty,
                     out_pitch_estimate, out_pitch_uncertainty);
        end
      end
    end
  end

  // ----------------------------------------------------------------- main

  initial begin
    dir_row_t dir_rows [$];
    int       send_pcts [3];
    int       recv_pcts [3];

    send_pcts = '{28, 66, 0};
    recv_pcts = '{66, 28, 0};
    filter_reset();

    // Reset defaults first, then a zero time step with zero noise, where
    // the first sample snaps onto the measurement and later ones meet a
    // zero denominator and keep the estimate. Extremes follow.
    dir_rows.push_back(item_row(mk_sample('0, '0, '0, '0), 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_TIME_STEP, 31'h7FFF_0000));
    dir_rows.push_back(cfg_row(CFG_RATE_VARIANCE, '0));
    dir_rows.push_back(cfg_row(CFG_MEASURE_VARIANCE, '0));
    dir_rows.push_back(item_row(mk_sample(S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b1,
                                mk_est(S32_MAX, '0, S32_MIN, '0)));
    dir_rows.push_back(item_row(mk_sample(S32_MIN, S32_MAX, '0, '0), 1'b1,
                                mk_est(S32_MAX, '0, S32_MIN, '0)));
    dir_rows.push_back(cfg_row(CFG_UNUSED_IDX, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(mk_sample(32'sd1, -32'sd1, -32'sd1, 32'sd1), 1'b1,
                                mk_est(S32_MAX, '0, S32_MIN, '0)));
    dir_rows.push_back(cfg_row(CFG_TIME_STEP, 31'h0000_FFFF));
    dir_rows.push_back(cfg_row(CFG_RATE_VARIANCE, 31'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_MEASURE_VARIANCE, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(mk_sample(S32_MAX, S32_MIN, S32_MIN, S32_MAX), 1'b0, '0));
    dir_rows.push_back(item_row(mk_sample(S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b0, '0));
    dir_rows.push_back(item_row(mk_sample(S32_MIN, S32_MAX, '0, '0), 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_TIME_STEP, 31'd1));
    dir_rows.push_back(cfg_row(CFG_RATE_VARIANCE, 31'd1));
    dir_rows.push_back(cfg_row(CFG_MEASURE_VARIANCE, 31'd1));
    dir_rows.push_back(item_row(mk_sample(32'sh0001_0000, -32'sh0001_0000,
                                          32'sh0005_0000, -32'sh0005_0000), 1'b0, '0));
    dir_rows.push_back(item_row(mk_sample('0, '0, '0, '0), 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_TIME_STEP, 31'd6554));
    dir_rows.push_back(cfg_row(CFG_RATE_VARIANCE, 31'd100 << FRAC));
    dir_rows.push_back(cfg_row(CFG_MEASURE_VARIANCE, 31'd9 << FRAC));
    dir_rows.push_back(item_row(mk_sample(32'sh000A_0000, -32'sh0014_0000,
                                          32'sh001E_0000, -32'sh002D_0000), 1'b0, '0));
    dir_rows.push_back(item_row(mk_sample(32'sh5555_5555, 32'shAAAA_AAAA,
                                          32'shAAAA_AAAA, 32'sh5555_5555), 1'b0, '0));
    dir_rows.push_back(item_row(mk_sample(-32'sd1, 32'sd1,
                                          32'sh00B4_0000, -32'sh00B4_0000), 1'b0, '0));

    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_for_estimates();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].est);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
        // The sender pauses here until every outstanding result is back.
        wait_for_estimates();
        send_idle_pct = send_pcts[mode];
        recv_idle_pct = recv_pcts[mode];
        shuffle_config();
        // A long receiver hold-off with the sender still offering fills
        // the block up so that it has to stall its input.
        if (mode == 0 && seg == 1) hold_request = 1'b1;
        for (int n = 0; n < SEG_ITEMS; n++)
          send_sample(mk_sample(rand_field(1'b1), rand_field(1'b1),
                                rand_field(1'b0), rand_field(1'b0)), 1'b0, '0);
      end
    end

    wait_for_estimates();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Covered %0d input and %0d result transactions and %0d register writes,",
             items_sent, results_seen, cfg_write_count);
    $display("under three idling profiles; %0d mismatches and %0d unexpected results.",
             mismatch_count, unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0 && estimate_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
